// File: design/hxf_pkg.sv
// ----------------------------------------------------------------------------
// hxf_pkg
// Shared types and constants for the 4x4 homogeneous transform block.
// ----------------------------------------------------------------------------
package hxf_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;

  localparam int WORD_W   = 32;
  localparam int IDX_W    = (DIM > 2) ? 2 : 1;
  localparam int PROD_W   = 2 * WORD_W;
  // exact sum of DIM products plus rounding constant, with one spare bit
  localparam int SUM_W    = PROD_W + $clog2(DIM) + 1;

  localparam int IN_TDATA_W  = 168;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 160;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_READ  = 2'd1,
    FN_IDENT = 2'd2,
    FN_XFORM = 2'd3
  } func_t;

  localparam word_t COEF_ONE = word_t'(1 << FRAC_BITS);

  typedef struct packed {
    func_t       func;
    logic [1:0]  row;
    logic [1:0]  col;
    word_t       coeff;
    word_t [3:0] vec;
  } cmd_t;

  typedef struct packed {
    func_t                       func;
    word_t                       read_value;
    prod_t [DIM-1:0][DIM-1:0]    prod;
  } mac_t;

  typedef struct packed {
    word_t       read_value;
    word_t [3:0] r;
    logic        overflow;
  } res_t;

endpackage

// File: design/hxf_in_stage.sv
// ----------------------------------------------------------------------------
// hxf_in_stage
// Input register: captures one command item per cycle while it is empty or the next stage takes its item.
// ----------------------------------------------------------------------------
module hxf_in_stage
  import hxf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  cmd_t up_cmd,
  output logic dn_valid,
  input  logic dn_ready,
  output cmd_t dn_cmd
);

  logic valid_r;
  cmd_t cmd_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_cmd   = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      cmd_r <= up_cmd;
    end
  end

endmodule

// File: design/hxf_mac_stage.sv
// ----------------------------------------------------------------------------
// hxf_mac_stage
// Coefficient matrix and the DIM x DIM product array. Matrix updates and
// reads happen as an item leaves the input register, so every item sees
// the matrix left by the items before it.
// ----------------------------------------------------------------------------
module hxf_mac_stage
  import hxf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  cmd_t up_cmd,
  output logic dn_valid,
  input  logic dn_ready,
  output mac_t dn_mac
);

  word_t coef_r [DIM][DIM];
  logic  valid_r;
  mac_t  mac_r;

  logic             take;
  logic             row_ok;
  logic             col_ok;
  logic [IDX_W-1:0] row_i;
  logic [IDX_W-1:0] col_i;
  word_t            read_c;
  prod_t [DIM-1:0][DIM-1:0] prod_c;

  assign up_ready = !valid_r || dn_ready;
  assign take     = up_valid && up_ready;
  assign dn_valid = valid_r;
  assign dn_mac   = mac_r;

  assign row_ok = int'(up_cmd.row) < DIM;
  assign col_ok = int'(up_cmd.col) < DIM;
  assign row_i  = up_cmd.row[IDX_W-1:0];
  assign col_i  = up_cmd.col[IDX_W-1:0];

  always_comb begin
    read_c = '0;
    if (up_cmd.func == FN_READ && row_ok && col_ok) begin
      read_c = coef_r[row_i][col_i];
    end
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        prod_c[i][j] = $signed(coef_r[i][j]) * $signed(up_cmd.vec[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          coef_r[i][j] <= (i == j) ? COEF_ONE : '0;
        end
      end
    end else begin
      if (up_ready) begin
        valid_r <= up_valid;
      end
      if (take) begin
        unique case (up_cmd.func)
          FN_WRITE: begin
            if (row_ok && col_ok) begin
              coef_r[row_i][col_i] <= up_cmd.coeff;
            end
          end
          FN_IDENT: begin
            for (int i = 0; i < DIM; i++) begin
              for (int j = 0; j < DIM; j++) begin
                coef_r[i][j] <= (i == j) ? COEF_ONE : '0;
              end
            end
          end
          FN_READ, FN_XFORM: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mac_r.func       <= up_cmd.func;
      mac_r.read_value <= read_c;
      mac_r.prod       <= prod_c;
    end
  end

endmodule

// File: design/hxf_out_stage.sv
// ----------------------------------------------------------------------------
// hxf_out_stage
// Row sums, round to nearest (ties up), saturate to 32 bits (transform only), result register.
// ----------------------------------------------------------------------------
module hxf_out_stage
  import hxf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  mac_t up_mac,
  output logic dn_valid,
  input  logic dn_ready,
  output res_t dn_res
);

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  logic valid_r;
  res_t res_r;
  res_t res_c;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_res   = res_r;

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] q;
    logic                    pos_ovf;
    logic                    neg_ovf;
    res_c            = '0;
    res_c.read_value = up_mac.read_value;
    for (int i = 0; i < DIM; i++) begin
      acc = HALF;
      for (int j = 0; j < DIM; j++) begin
        acc = acc + SUM_W'(up_mac.prod[i][j]);
      end
      q       = acc >>> FRAC_BITS;
      // upper bits must all match the 32-bit sign bit
      pos_ovf = !q[SUM_W-1] && (|q[SUM_W-2:WORD_W-1]);
      neg_ovf = q[SUM_W-1] && !(&q[SUM_W-2:WORD_W-1]);
      if (up_mac.func == FN_XFORM) begin
        if (pos_ovf) begin
          res_c.r[i] = WORD_MAX;
        end else if (neg_ovf) begin
          res_c.r[i] = WORD_MIN;
        end else begin
          res_c.r[i] = q[WORD_W-1:0];
        end
        res_c.overflow = res_c.overflow | pos_ovf | neg_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      res_r <= res_c;
    end
  end

endmodule

// File: design/homogeneous_4x4_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_4x4_transform
// 4x4 Q16.16 coefficient matrix with write, read, identity and
// matrix-vector transform commands; one result per command.
//
//   channel | dir | tdata (low bit up)                        | tuser
//   --------+-----+-------------------------------------------+----------
//   in_     | in  | row, col, coeff, vx, vy, vz, vw, 4'b0     | func
//   out_    | out | rx, ry, rz, rw, read_value                | overflow
//
// Three register stages: input, products, result. One item per cycle
// sustained while out_tready is high; an item passes the three registers
// in that order before its result is valid. The 16 parallel 32x32
// multipliers feed the product register, the sum/round/saturate the result.
// Reset restores the identity matrix and empties the pipeline.
// Each stage loads when empty or when the next stage moves, so bubbles
// still fill while a result waits on out_tready.
// ----------------------------------------------------------------------------
module homogeneous_4x4_transform
  import hxf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // row[1:0], col[3:2], coeff[35:4], vx[67:36], vy[99:68], vz[131:100],
  // vw[163:132], zero pad [167:164]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // rx[31:0], ry[63:32], rz[95:64], rw[127:96], read_value[159:128]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // overflow
  output logic                   out_tuser
);

  cmd_t in_cmd;
  cmd_t s1_cmd;
  logic s1_valid;
  logic s1_ready;
  mac_t s2_mac;
  logic s2_valid;
  logic s2_ready;
  res_t res;

  always_comb begin
    in_cmd.func  = func_t'(in_tuser);
    in_cmd.row   = in_tdata[1:0];
    in_cmd.col   = in_tdata[3:2];
    in_cmd.coeff = in_tdata[35:4];
    in_cmd.vec   = in_tdata[163:36];
  end

  hxf_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_cmd   (in_cmd),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_cmd   (s1_cmd)
  );

  hxf_mac_stage u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_cmd   (s1_cmd),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_mac   (s2_mac)
  );

  hxf_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_mac   (s2_mac),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_res   (res)
  );

  assign out_tdata = {res.read_value, res.r};
  assign out_tuser = res.overflow;

endmodule
